// ===== rtl/dfff_pkg.sv =====
// Shared types, constants and helpers for the distance field follow force block.
// Used by every module under rtl; depends on nothing.
package dfff_pkg;

   // Fixed point format and vector sizes
   localparam int DIM       = 3;
   localparam int NCOMP     = 3;
   localparam int FRAC_BITS = 16;
   localparam int DW        = 32;

   // Datapath widths: signed working width, multiplier operand magnitudes
   localparam int W   = 52;
   localparam int AMW = 36;
   localparam int BMW = 32;
   localparam int PW  = AMW + BMW;
   localparam int BW  = BMW + 1;
   localparam int DVW = DW + FRAC_BITS;
   localparam int IDXW = (DIM > 2) ? $clog2(DIM) : 1;

   // Stream widths
   localparam int IN_W  = 3 * NCOMP * DW;
   localparam int OUT_W = NCOMP * DW;

   // Input queue
   localparam int QDEPTH = 4;
   localparam int QPW    = $clog2(QDEPTH);

   // Configuration register indexes
   localparam int CSR_IW = 3;
   localparam logic [CSR_IW-1:0] CSR_ENABLE  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_MIN     = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_MAX     = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_ORT     = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_TAN     = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_OVERALL = 3'd5;

   localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

   typedef logic [NCOMP-1:0][DW-1:0] vec_type;

   typedef struct packed {
      vec_type field;
      vec_type vel;
      vec_type force_in;
      logic    last;
   } item_type;

   typedef struct packed {
      logic          enable;
      logic [30:0]   min_dist;
      logic [30:0]   max_dist;
      logic [DW-1:0] ort_gain;
      logic [DW-1:0] tan_gain;
      logic [DW-1:0] overall_gain;
   } cfg_type;

   // Magnitude of a signed 32-bit value, as unsigned
   function automatic logic [DW-1:0] mag32(input logic [DW-1:0] v);
      mag32 = v[DW-1] ? (~v + 1'b1) : v;
   endfunction

   // Sign-extend a 32-bit value to the working width
   function automatic logic signed [W-1:0] sx_w(input logic [DW-1:0] v);
      sx_w = W'($signed(v));
   endfunction

   // Sign-extend a 32-bit value to the multiplier B width
   function automatic logic signed [BW-1:0] sx_b(input logic [DW-1:0] v);
      sx_b = BW'($signed(v));
   endfunction

endpackage

// ===== rtl/dfff_front.sv =====
// Input stage: takes stream transfers, unpacks them into queue items.
// Depends on dfff_pkg.
module dfff_front import dfff_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   // field_x, field_y, field_z, vel_x, vel_y, vel_z, force_in_x, force_in_y, force_in_z
   input  logic [IN_W-1:0] req_tdata,
   input  logic            req_tlast,
   output logic            push,
   output item_type        push_item,
   input  logic            full
);

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   // Unpack the bus into an item
   always_comb begin
      for (int i = 0; i < NCOMP; i++) begin
         item_in.field[i]    = req_tdata[i*DW +: DW];
         item_in.vel[i]      = req_tdata[(NCOMP + i)*DW +: DW];
         item_in.force_in[i] = req_tdata[(2*NCOMP + i)*DW +: DW];
      end
      item_in.last = req_tlast;
   end

   assign push       = valid_ff && !full;
   assign req_tready = !valid_ff || !full;
   assign push_item  = item_ff;

   // Hold one item until the queue takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== rtl/dfff_fifo.sv =====
// Short queue between the input stage and the compute engine.
// Depends on dfff_pkg.
module dfff_fifo import dfff_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   item_type         mem_ff [QDEPTH];
   logic [QPW-1:0]   wr_ptr_ff;
   logic [QPW-1:0]   rd_ptr_ff;
   logic [QPW:0]     count_ff;

   assign full     = (count_ff == (QPW+1)'(QDEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// ===== rtl/dfff_sqrt.sv =====
// Bit-serial integer square root: two radicand bits per cycle.
// Depends on dfff_pkg.
module dfff_sqrt import dfff_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   value,
   output logic          done,
   output logic [DW-1:0] root
);

   localparam int STEPS = 32;
   localparam int CW    = $clog2(STEPS);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [63:0]   rad_ff, rad_in;
   logic [34:0]   rem_ff, rem_in;
   logic [DW-1:0] root_ff, root_in;
   logic [34:0]   rem_n;
   logic [34:0]   trial;

   assign rem_n = {rem_ff[32:0], rad_ff[63:62]};
   assign trial = {1'b0, root_ff, 2'b01};

   // One root digit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (rem_n >= trial) begin
            rem_in  = rem_n - trial;
            root_in = {root_ff[DW-2:0], 1'b1};
         end else begin
            rem_in  = rem_n;
            root_in = {root_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/dfff_div.sv =====
// Restoring divider: one quotient bit per cycle over the dividend width.
// Depends on dfff_pkg.
module dfff_div import dfff_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [DW-1:0]  divisor,
   output logic           done,
   output logic [DVW-1:0] quot
);

   localparam int CW = $clog2(DVW);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [DVW-1:0] dvd_ff, dvd_in;
   logic [DW-1:0]  dvs_ff, dvs_in;
   logic [DW-1:0]  rem_ff, rem_in;
   logic [DW:0]    rem_n;
   logic [DW:0]    diff;

   assign rem_n = {rem_ff, dvd_ff[DVW-1]};
   assign diff  = rem_n - {1'b0, dvs_ff};

   // Shift in one dividend bit, subtract when it fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (rem_n >= {1'b0, dvs_ff}) begin
            rem_in = diff[DW-1:0];
            dvd_in = {dvd_ff[DVW-2:0], 1'b1};
         end else begin
            rem_in = rem_n[DW-1:0];
            dvd_in = {dvd_ff[DVW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DVW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = dvd_ff;

endmodule

// ===== rtl/dfff_back.sv =====
// Compute engine: vector lengths, nearest-in-band tracking and the force update.
// Depends on dfff_pkg, dfff_sqrt and dfff_div.
module dfff_back import dfff_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             q_empty,
   input  item_type         q_item,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata,
   output logic             rsp_tuser
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ_MUL, ST_SQ_ACC, ST_LEN, ST_LEN_WAIT, ST_R, ST_R_WAIT, ST_S_WAIT,
      ST_UNIT, ST_UNIT_WAIT, ST_DOT_MUL, ST_DOT_ACC, ST_TAN_MUL, ST_TAN_SUB,
      ST_TERM_MUL, ST_TERM_ACC
   } state_type;

   localparam logic signed [W-1:0] LIM    = W'(64'sd4294967295);
   localparam logic signed [W-1:0] SAT_HI = W'(64'sd2147483647);
   localparam logic signed [W-1:0] SAT_LO = W'(-64'sd2147483648);

   typedef logic [NCOMP-1:0][W-1:0] wvec_type;

   state_type       state_ff, state_in;
   logic [IDXW-1:0] idx_ff, idx_in;
   logic [2:0]      step_ff, step_in;
   logic            phase_vel_ff, phase_vel_in;
   logic            unit_vel_ff, unit_vel_in;
   item_type        item_ff, item_in;
   logic [DW-1:0]   best_len_ff, best_len_in;
   vec_type         best_vec_ff, best_vec_in;
   logic            found_ff, found_in;
   logic [63:0]     acc_ff, acc_in;
   logic [DW-1:0]   vlen_ff, vlen_in;
   logic [FRAC_BITS:0] s_ff, s_in;
   wvec_type        u_ff, u_in;
   wvec_type        n_ff, n_in;
   wvec_type        t_ff, t_in;
   logic signed [W-1:0] dot_ff, dot_in;
   logic signed [W-1:0] p_ff, p_in;
   logic signed [W-1:0] p2_ff, p2_in;
   vec_type         out_ff, out_in;
   logic            appl_ff, appl_in;
   logic [PW-1:0]   prod_ff, prod_in;
   logic            neg_ff, neg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   vec_type         rsp_data_ff, rsp_data_in;
   logic            rsp_user_ff, rsp_user_in;

   // Shared multiplier operands and product
   logic signed [W-1:0]  mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [W-1:0]  amag_w;
   logic signed [BW-1:0] bmag_w;
   logic [PW-1:0]        prod_calc;
   logic [PW-1:0]        prod_sh;
   logic signed [W-1:0]  qv;

   // Iterative units
   logic           sq_start;
   logic [63:0]    sq_value;
   logic           sq_done;
   logic [DW-1:0]  sq_root;
   logic           dv_start;
   logic [DVW-1:0] dv_dividend;
   logic [DW-1:0]  dv_divisor;
   logic           dv_done;
   logic [DVW-1:0] dv_quot;

   dfff_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sq_value),
      .done  (sq_done),
      .root  (sq_root)
   );

   dfff_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_dividend),
      .divisor  (dv_divisor),
      .done     (dv_done),
      .quot     (dv_quot)
   );

   // Magnitude product, then truncated fixed-point result with sign restored
   assign amag_w    = mul_a[W-1] ? -mul_a : mul_a;
   assign bmag_w    = mul_b[BW-1] ? -mul_b : mul_b;
   assign prod_calc = PW'(amag_w[AMW-1:0]) * PW'(bmag_w[BMW-1:0]);
   assign prod_sh   = prod_ff >> FRAC_BITS;
   assign qv        = neg_ff ? -$signed(prod_sh[W-1:0]) : $signed(prod_sh[W-1:0]);

   always_comb begin : next_logic
      logic [DW-1:0]       len_v;
      logic                inband_v;
      logic [DW-1:0]       vsel_v;
      logic [DW-1:0]       lsel_v;
      logic signed [W-1:0] m_v;
      logic signed [W-1:0] sum_v;
      logic [DW-1:0]       num_v;
      logic [FRAC_BITS:0]  r_v;
      logic                adv_v;

      len_v    = sq_root;
      inband_v = 1'b0;
      vsel_v   = unit_vel_ff ? item_ff.vel[idx_ff] : best_vec_ff[idx_ff];
      lsel_v   = unit_vel_ff ? vlen_ff : best_len_ff;
      m_v      = W'(dv_quot);
      sum_v    = '0;
      num_v    = (best_len_ff > DW'(cfg.min_dist)) ? best_len_ff - DW'(cfg.min_dist) : '0;
      r_v      = (dv_quot > DVW'(ONE_Q)) ? ONE_Q : dv_quot[FRAC_BITS:0];
      adv_v    = 1'b0;

      state_in     = state_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      phase_vel_in = phase_vel_ff;
      unit_vel_in  = unit_vel_ff;
      item_in      = item_ff;
      best_len_in  = best_len_ff;
      best_vec_in  = best_vec_ff;
      found_in     = found_ff;
      acc_in       = acc_ff;
      vlen_in      = vlen_ff;
      s_in         = s_ff;
      u_in         = u_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      dot_in       = dot_ff;
      p_in         = p_ff;
      p2_in        = p2_ff;
      out_in       = out_ff;
      appl_in      = appl_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      q_pop        = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      sq_start     = 1'b0;
      sq_value     = acc_ff;
      dv_start     = 1'b0;
      dv_dividend  = {mag32(vsel_v), {FRAC_BITS{1'b0}}};
      dv_divisor   = lsel_v;

      case (state_ff)
         // Take the next queued vector
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop        = 1'b1;
               item_in      = q_item;
               acc_in       = '0;
               idx_in       = '0;
               phase_vel_in = 1'b0;
               state_in     = ST_SQ_MUL;
            end
         end
         // Sum of squares, one component per multiply
         ST_SQ_MUL: begin
            mul_a    = phase_vel_ff ? sx_w(item_ff.vel[idx_ff]) : sx_w(item_ff.field[idx_ff]);
            mul_b    = phase_vel_ff ? sx_b(item_ff.vel[idx_ff]) : sx_b(item_ff.field[idx_ff]);
            prod_in  = prod_calc;
            neg_in   = 1'b0;
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            acc_in = acc_ff + prod_ff[63:0];
            if (idx_ff == IDXW'(DIM - 1)) begin
               idx_in   = '0;
               state_in = ST_LEN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SQ_MUL;
            end
         end
         ST_LEN: begin
            sq_start = 1'b1;
            state_in = ST_LEN_WAIT;
         end
         // Band check and nearest update, or velocity length
         ST_LEN_WAIT: begin
            if (sq_done) begin
               if (!phase_vel_ff) begin
                  inband_v = !((cfg.min_dist != '0) && (len_v < DW'(cfg.min_dist))) &&
                             !((cfg.max_dist != '0) && (len_v > DW'(cfg.max_dist)));
                  if (inband_v) begin
                     found_in = 1'b1;
                     if (len_v < best_len_ff) begin
                        best_len_in = len_v;
                        best_vec_in = item_ff.field;
                     end
                  end
                  if (item_ff.last) begin
                     out_in  = item_ff.force_in;
                     appl_in = 1'b0;
                     if (cfg.enable && (found_ff || inband_v)) begin
                        phase_vel_in = 1'b1;
                        acc_in       = '0;
                        idx_in       = '0;
                        state_in     = ST_SQ_MUL;
                     end else begin
                        state_in = ST_TERM_ACC;
                        step_in  = 3'd5;
                     end
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  vlen_in  = len_v;
                  state_in = ST_R;
               end
            end
         end
         // Band ratio r, clamped
         ST_R: begin
            if (cfg.max_dist <= cfg.min_dist) begin
               sq_start = 1'b1;
               sq_value = 64'(ONE_Q) << FRAC_BITS;
               state_in = ST_S_WAIT;
            end else begin
               dv_start    = 1'b1;
               dv_dividend = {num_v, {FRAC_BITS{1'b0}}};
               dv_divisor  = DW'(cfg.max_dist - cfg.min_dist);
               state_in    = ST_R_WAIT;
            end
         end
         ST_R_WAIT: begin
            if (dv_done) begin
               sq_start = 1'b1;
               sq_value = 64'(r_v) << FRAC_BITS;
               state_in = ST_S_WAIT;
            end
         end
         ST_S_WAIT: begin
            if (sq_done) begin
               s_in        = sq_root[FRAC_BITS:0];
               idx_in      = '0;
               unit_vel_in = 1'b0;
               state_in    = ST_UNIT;
            end
         end
         // Unit vectors of the nearest vector, then of the velocity
         ST_UNIT: begin
            if (lsel_v == '0) begin
               if (unit_vel_ff) n_in[idx_ff] = '0;
               else             u_in[idx_ff] = '0;
               adv_v = 1'b1;
            end else begin
               dv_start = 1'b1;
               state_in = ST_UNIT_WAIT;
            end
         end
         ST_UNIT_WAIT: begin
            if (dv_done) begin
               if (vsel_v[DW-1]) m_v = -m_v;
               if (unit_vel_ff) n_in[idx_ff] = m_v;
               else             u_in[idx_ff] = m_v;
               adv_v = 1'b1;
            end
         end
         // Dot product u . n
         ST_DOT_MUL: begin
            mul_a    = $signed(u_ff[idx_ff]);
            mul_b    = $signed(n_ff[idx_ff][BW-1:0]);
            prod_in  = prod_calc;
            neg_in   = (mul_a < 0) != (mul_b < 0);
            state_in = ST_DOT_ACC;
         end
         ST_DOT_ACC: begin
            dot_in = dot_ff + qv;
            if (idx_ff == IDXW'(DIM - 1)) begin
               idx_in   = '0;
               state_in = ST_TAN_MUL;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_DOT_MUL;
            end
         end
         // Tangential part t = n - u * dot
         ST_TAN_MUL: begin
            mul_a    = $signed(u_ff[idx_ff]);
            mul_b    = dot_ff[BW-1:0];
            prod_in  = prod_calc;
            neg_in   = (mul_a < 0) != (mul_b < 0);
            state_in = ST_TAN_SUB;
         end
         ST_TAN_SUB: begin
            t_in[idx_ff] = $signed(n_ff[idx_ff]) - qv;
            if (idx_ff == IDXW'(DIM - 1)) begin
               idx_in   = '0;
               step_in  = '0;
               state_in = ST_TERM_MUL;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_TAN_MUL;
            end
         end
         // Product chain of one component's force term
         ST_TERM_MUL: begin
            case (step_ff)
               3'd0: begin
                  mul_a = $signed(u_ff[idx_ff]);
                  mul_b = sx_b(cfg.ort_gain);
               end
               3'd1: begin
                  mul_a = p_ff;
                  mul_b = $signed(BW'(s_ff));
               end
               3'd2: begin
                  mul_a = $signed(t_ff[idx_ff]);
                  mul_b = sx_b(cfg.tan_gain);
               end
               3'd3: begin
                  mul_a = p_ff;
                  mul_b = $signed(BW'(ONE_Q - s_ff));
               end
               default: begin
                  mul_a = p_ff;
                  mul_b = sx_b(cfg.overall_gain);
               end
            endcase
            prod_in  = prod_calc;
            neg_in   = (mul_a < 0) != (mul_b < 0);
            state_in = ST_TERM_ACC;
         end
         // Collect each product; step five sends the result out
         ST_TERM_ACC: begin
            case (step_ff)
               3'd0, 3'd2: begin
                  p_in     = qv;
                  step_in  = step_ff + 1'b1;
                  state_in = ST_TERM_MUL;
               end
               3'd1: begin
                  p2_in    = qv;
                  step_in  = step_ff + 1'b1;
                  state_in = ST_TERM_MUL;
               end
               3'd3: begin
                  sum_v = p2_ff + qv;
                  if (sum_v > LIM)  sum_v = LIM;
                  if (sum_v < -LIM) sum_v = -LIM;
                  p_in     = sum_v;
                  step_in  = step_ff + 1'b1;
                  state_in = ST_TERM_MUL;
               end
               3'd4: begin
                  sum_v = sx_w(item_ff.force_in[idx_ff]) + qv;
                  if (sum_v > SAT_HI)      out_in[idx_ff] = 32'h7FFF_FFFF;
                  else if (sum_v < SAT_LO) out_in[idx_ff] = 32'h8000_0000;
                  else                     out_in[idx_ff] = sum_v[DW-1:0];
                  step_in = '0;
                  if (idx_ff == IDXW'(DIM - 1)) begin
                     appl_in = 1'b1;
                     step_in = 3'd5;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = ST_TERM_MUL;
                  end
               end
               default: begin
                  if (!rsp_valid_ff || rsp_tready) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = out_ff;
                     rsp_user_in  = appl_ff;
                     best_len_in  = '1;
                     best_vec_in  = '0;
                     found_in     = 1'b0;
                     step_in      = '0;
                     state_in     = ST_IDLE;
                  end
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Step through unit vector components
      if (adv_v) begin
         if (idx_ff == IDXW'(DIM - 1)) begin
            idx_in = '0;
            if (unit_vel_ff) begin
               dot_in   = '0;
               state_in = ST_DOT_MUL;
            end else begin
               unit_vel_in = 1'b1;
               state_in    = ST_UNIT;
            end
         end else begin
            idx_in   = idx_ff + 1'b1;
            state_in = ST_UNIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         best_len_ff  <= '1;
         best_vec_ff  <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         best_len_ff  <= best_len_in;
         best_vec_ff  <= best_vec_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      phase_vel_ff <= phase_vel_in;
      unit_vel_ff  <= unit_vel_in;
      item_ff      <= item_in;
      acc_ff       <= acc_in;
      vlen_ff      <= vlen_in;
      s_ff         <= s_in;
      u_ff         <= u_in;
      n_ff         <= n_in;
      t_ff         <= t_in;
      dot_ff       <= dot_in;
      p_ff         <= p_in;
      p2_ff        <= p2_in;
      out_ff       <= out_in;
      appl_ff      <= appl_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/distance_field_follow_force.sv =====
// Top level of the distance field follow force block: registers, input stage,
// queue and compute engine. Depends on dfff_pkg, dfff_front, dfff_fifo, dfff_back.
//
// Usage: each req_ transfer carries one field vector of an agent plus its
// velocity and current force; req_tlast marks the agent's final vector. The
// block keeps the shortest vector whose length falls inside the configured
// band. On the final vector it sends one rsp_ transfer with the updated force
// (rsp_tuser high when a force was added, low when the force passed through).
// Other vectors produce no transfer.
// Throughput: the input stage takes one transfer per cycle until its holding
// register and the 4-entry queue are full. The engine takes one vector at a
// time, paced by the bit-serial square root of the length. A final vector adds
// work for the serial divider (ratio and six unit components), two more square
// root passes and the shared multiplier chain.
// Reset restores the register defaults and clears the nearest-vector state.
// A stalled rsp_tready holds the result in its output register; the queue
// keeps filling meanwhile and then deasserts req_tready.
module distance_field_follow_force import dfff_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // field_x, field_y, field_z, vel_x, vel_y, vel_z, force_in_x, force_in_y, force_in_z
   input  logic [IN_W-1:0]   req_tdata,
   // last_vector
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // force_out_x, force_out_y, force_out_z
   output logic [OUT_W-1:0]  rsp_tdata,
   // applied
   output logic              rsp_tuser,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [DW-1:0]     csr_wdata
);

   cfg_type  cfg_ff;
   logic     push;
   item_type push_item;
   logic     full;
   logic     pop;
   item_type pop_item;
   logic     empty;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable       <= 1'b1;
         cfg_ff.min_dist     <= '0;
         cfg_ff.max_dist     <= 31'd65536;
         cfg_ff.ort_gain     <= 32'd65536;
         cfg_ff.tan_gain     <= 32'd65536;
         cfg_ff.overall_gain <= 32'd6554;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:  cfg_ff.enable       <= csr_wdata[0];
            CSR_MIN:     cfg_ff.min_dist     <= csr_wdata[30:0];
            CSR_MAX:     cfg_ff.max_dist     <= csr_wdata[30:0];
            CSR_ORT:     cfg_ff.ort_gain     <= csr_wdata;
            CSR_TAN:     cfg_ff.tan_gain     <= csr_wdata;
            CSR_OVERALL: cfg_ff.overall_gain <= csr_wdata;
            default: ;
         endcase
      end
   end

   dfff_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_item  (push_item),
      .full       (full)
   );

   dfff_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (empty)
   );

   dfff_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (empty),
      .q_item     (pop_item),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== test/distance_field_follow_force_test.sv =====
// Testbench for distance_field_follow_force: streams agent frames of field vectors,
// predicts each updated force in 64-bit fixed point and checks every rsp_ transfer.
// Depends on dfff_pkg and the distance_field_follow_force RTL.
`timescale 1ns / 100ps

module distance_field_follow_force_test;
   import dfff_pkg::*;

   localparam int  HOLD_CYCLES = 4000;
   localparam int  SETTLE      = 800;
   localparam longint LIMIT    = 3000000;

   typedef struct {
      logic [8:0][31:0] words;
      logic             last;
   } vector_item;

   typedef struct {
      logic [31:0] fx, fy, fz;
      logic        applied;
   } force_result;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [IN_W-1:0]   req_tdata = '0;
   logic              req_tlast = 0;
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic [OUT_W-1:0]  rsp_tdata;
   logic              rsp_tuser;
   logic              csr_we = 0;
   logic [CSR_IW-1:0] csr_index = CSR_ENABLE;
   logic [DW-1:0]     csr_wdata = '0;

   distance_field_follow_force dut (.*);

   always #6 clock = ~clock;

   // Mirror of the configuration registers
   longint unsigned m_enable = 1, m_min = 0, m_max = 65536;
   longint          m_ort = 65536, m_tan = 65536, m_overall = 6554;
   // Nearest-vector accumulator
   longint unsigned near_len = 64'hFFFFFFFF;
   longint          near_vec[3] = '{0, 0, 0};
   bit              near_found = 0;

   vector_item  pending[$];
   force_result expected_forces[$];
   int          errors = 0;
   longint      cycle = 0;
   longint      offered = 0, accepted = 0;

   function automatic longint unsigned mg(longint a);
      return a < 0 ? longint'(-a) : longint'(a);
   endfunction

   function automatic longint qmul(longint a, longint b);
      longint unsigned p;
      p = (mg(a) * mg(b)) >> FRAC_BITS;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned length3(longint v[3]);
      return root64(mg(v[0]) * mg(v[0]) + mg(v[1]) * mg(v[1]) + mg(v[2]) * mg(v[2]));
   endfunction

   function automatic void normalize(longint v[3], longint unsigned len, ref longint u[3]);
      longint m;
      for (int i = 0; i < 3; i++) begin
         u[i] = 0;
         if (len != 0) begin
            m = longint'((mg(v[i]) << FRAC_BITS) / len);
            u[i] = v[i] < 0 ? -m : m;
         end
      end
   endfunction

   // Fold one accepted vector into the accumulator; on a last vector queue the force
   function automatic void track_nearest(logic [8:0][31:0] w, logic last);
      longint f[3], vel[3], fin[3], u[3], n[3], tg[3], outv[3];
      longint one, r, s, dot, term, delta, sum, lim;
      longint unsigned len, num, q;
      force_result res;
      one = longint'(1) << FRAC_BITS;
      lim = 64'd4294967295;
      for (int i = 0; i < 3; i++) begin
         f[i]    = longint'(signed'(w[i]));
         vel[i]  = longint'(signed'(w[3 + i]));
         fin[i]  = longint'(signed'(w[6 + i]));
         outv[i] = fin[i];
      end
      len = length3(f);
      if (!(m_min > 0 && len < m_min) && !(m_max > 0 && len > m_max)) begin
         if (len < near_len) begin
            near_len = len;
            near_vec = f;
         end
         near_found = 1;
      end
      if (!last) return;
      res.applied = 0;
      if (m_enable != 0 && near_found) begin
         if (m_max <= m_min) begin
            r = one;
         end else begin
            num = near_len > m_min ? near_len - m_min : 0;
            q = (num << FRAC_BITS) / (m_max - m_min);
            r = q > one ? one : longint'(q);
         end
         s = longint'(root64(longint'(r) << FRAC_BITS));
         normalize(near_vec, near_len, u);
         normalize(vel, length3(vel), n);
         dot = 0;
         for (int i = 0; i < 3; i++) dot += qmul(u[i], n[i]);
         for (int i = 0; i < 3; i++) begin
            tg[i] = n[i] - qmul(u[i], dot);
            term = qmul(qmul(u[i], m_ort), s) + qmul(qmul(tg[i], m_tan), one - s);
            if (term > lim) term = lim;
            if (term < -lim) term = -lim;
            delta = qmul(term, m_overall);
            sum = fin[i] + delta;
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            outv[i] = sum;
         end
         res.applied = 1;
      end
      res.fx = outv[0][31:0];
      res.fy = outv[1][31:0];
      res.fz = outv[2][31:0];
      expected_forces.push_back(res);
      near_len = 64'hFFFFFFFF;
      near_vec = '{0, 0, 0};
      near_found = 0;
   endfunction

   // Sender: bursts of random length separated by random gaps
   int burst_left = 0, gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && accepted < offered) begin
            // hold the current item until its transfer
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 0;
         end else if (pending.size() > 0) begin
            req_tdata  <= pending[0].words;
            req_tlast  <= pending[0].last;
            void'(pending.pop_front());
            req_tvalid <= 1;
            offered    <= offered + 1;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 20);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
            end
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // Receiver: randomly chosen stall patterns plus one long hold-off
   int hold_left = 0;
   int stall_mode = 0;
   always @(negedge clock) begin
      if (cycle == 30000) hold_left = HOLD_CYCLES;
      if (cycle % 700 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else case (stall_mode)
         0: rsp_tready <= 1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // Monitor: predict on each req_ transfer, check each rsp_ transfer
   always @(posedge clock) begin
      force_result e;
      cycle <= cycle + 1;
      if (cycle > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset && req_tvalid && req_tready) begin
         accepted <= accepted + 1;
         track_nearest(req_tdata, req_tlast);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_forces.size() == 0) begin
            $error("unexpected force result %h", rsp_tdata);
            errors++;
         end else begin
            e = expected_forces.pop_front();
            if (rsp_tdata[31:0] !== e.fx) begin
               $error("force_out_x expected %h actual %h", e.fx, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== e.fy) begin
               $error("force_out_y expected %h actual %h", e.fy, rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tdata[95:64] !== e.fz) begin
               $error("force_out_z expected %h actual %h", e.fz, rsp_tdata[95:64]);
               errors++;
            end
            if (rsp_tuser !== e.applied) begin
               $error("applied expected %b actual %b", e.applied, rsp_tuser);
               errors++;
            end
         end
      end
   end

   task automatic add_vec(logic [31:0] fx, fy, fz, vx, vy, vz, gx, gy, gz, logic last);
      vector_item it;
      it.words = {gz, gy, gx, vz, vy, vx, fz, fy, fx};
      it.last  = last;
      pending.push_back(it);
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ENABLE:  m_enable  = val & 1;
         CSR_MIN:     m_min     = val & 32'h7FFFFFFF;
         CSR_MAX:     m_max     = val & 32'h7FFFFFFF;
         CSR_ORT:     m_ort     = longint'(signed'(val));
         CSR_TAN:     m_tan     = longint'(signed'(val));
         CSR_OVERALL: m_overall = longint'(signed'(val));
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 0;
   endtask

   // Component near the band: mostly scaled, sometimes zero or fully random
   function automatic logic [31:0] pick_comp(longint unsigned scale);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return $urandom;
      if (sel == 1) return 0;
      return 32'($urandom_range(0, 32'(scale)) - longint'(scale / 2));
   endfunction

   function automatic logic [31:0] pick_wide();
      return ($urandom_range(0, 1) == 0) ? $urandom : 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
   endfunction

   task automatic wait_idle();
      while (pending.size() > 0 || accepted < offered || expected_forces.size() > 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic random_frames(int count);
      longint unsigned scale;
      int flen;
      scale = m_max != 0 ? m_max : 32'h40000;
      if (scale > 32'h7FFFFFFE) scale = 32'h7FFFFFFE;
      while (count > 0) begin
         flen = $urandom_range(1, 8);
         for (int k = 0; k < flen; k++)
            add_vec(pick_comp(scale), pick_comp(scale), pick_comp(scale),
                    pick_wide(), pick_wide(), pick_wide(),
                    pick_wide(), pick_wide(), pick_wide(), k == flen - 1);
         count -= flen;
      end
   endtask

   initial begin
      logic [31:0] settings[6][6];
      settings = '{
         '{1, 32'h8000, 32'h40000, 32'h10000, 32'h8000, 32'h10000},
         '{0, 32'h8000, 32'h40000, 32'h10000, 32'h8000, 32'h10000},
         '{1, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF},
         '{1, 32'h30000, 32'h10000, 32'hFFFF0000, 32'h20000, 32'h8000},
         '{1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000},
         '{1, 32'h100, 32'h7FFFFFFF, $urandom, $urandom, 32'h1000}};
      repeat (5) @(negedge clock);
      reset <= 0;

      // Directed frames under the reset settings
      add_vec(0, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h10000, 1);
      add_vec(32'h8000, 0, 0, 32'h10000, 0, 0, 0, 0, 0, 0);
      add_vec(0, 32'h8000, 0, 32'h10000, 0, 0, 0, 0, 0, 0);
      add_vec(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0);
      add_vec(32'h4000, 32'h4000, 0, 32'h10000, 32'h10000, 0,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1);
      add_vec(32'h20000, 0, 0, 32'h10000, 0, 0, 32'h1234, 32'h5678, 32'h9ABC, 1);
      add_vec(32'h10000, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000, 0);
      add_vec(32'hFFFF0000, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000, 1);
      add_vec(0, 32'hFFFFC000, 32'h2000, 0, 0, 0, 32'hFFFFFFFF, 1, 0, 1);
      add_vec(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF, 0, 0, 0, 1);
      random_frames(300);
      wait_idle();

      // Walk through the register settings
      foreach (settings[p]) begin
         write_reg(CSR_ENABLE,  settings[p][0]);
         write_reg(CSR_MIN,     settings[p][1]);
         write_reg(CSR_MAX,     settings[p][2]);
         write_reg(CSR_ORT,     settings[p][3]);
         write_reg(CSR_TAN,     settings[p][4]);
         write_reg(CSR_OVERALL, settings[p][5]);
         random_frames(280);
         wait_idle();
      end

      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/dfff_pkg.sv
rtl/dfff_front.sv
rtl/dfff_fifo.sv
rtl/dfff_sqrt.sv
rtl/dfff_div.sv
rtl/dfff_back.sv
rtl/distance_field_follow_force.sv
test/distance_field_follow_force_test.sv
